[hw/rtl/max_priority_table_with_promote_defines.svh]
// Assertion macros shared by the checker.
`ifndef MAX_PRIORITY_TABLE_WITH_PROMOTE_DEFINES_SVH
`define MAX_PRIORITY_TABLE_WITH_PROMOTE_DEFINES_SVH

// same-cycle implication
`define MPT_AST_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define MPT_AST_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[hw/rtl/mpt_pkg.sv]
package mpt_pkg;

    localparam int DEF_ENTRIES        = 64;
    localparam int DEF_OBJECT_WIDTH   = 32;
    localparam int DEF_PRIORITY_WIDTH = 16;

    localparam logic [2:0] K_ADD     = 3'd0;
    localparam logic [2:0] K_PROMOTE = 3'd1;
    localparam logic [2:0] K_PEEK    = 3'd2;
    localparam logic [2:0] K_POP     = 3'd3;
    localparam logic [2:0] K_LOOKUP  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BADID = 2'd3;

    // control part of the token walking down the cell chain
    typedef struct packed {
        logic       vld;
        logic [2:0] kind;
        logic [1:0] pre;    // status settled at entry; cells act only on ST_OK
        logic       found;
    } t_ctrl;

endpackage

[hw/rtl/mpt_cell.sv]
module mpt_cell import mpt_pkg::*; #(
    parameter int ENTRIES        = DEF_ENTRIES,
    parameter int OBJECT_WIDTH   = DEF_OBJECT_WIDTH,
    parameter int PRIORITY_WIDTH = DEF_PRIORITY_WIDTH,
    parameter int INDEX          = 0,
    localparam int IW            = $clog2(ENTRIES)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctrl                     i_ctrl,
    input  logic [IW-1:0]             i_id,
    input  logic [OBJECT_WIDTH-1:0]   i_obj,
    input  logic [IW-1:0]             i_rid,
    input  logic [OBJECT_WIDTH-1:0]   i_robj,
    input  logic [PRIORITY_WIDTH-1:0] i_rpri,
    input  logic                      i_rlive,
    input  logic                      i_clr,
    input  logic [IW-1:0]             i_clr_id,
    output t_ctrl                     o_ctrl,
    output logic [IW-1:0]             o_id,
    output logic [OBJECT_WIDTH-1:0]   o_obj,
    output logic [IW-1:0]             o_rid,
    output logic [OBJECT_WIDTH-1:0]   o_robj,
    output logic [PRIORITY_WIDTH-1:0] o_rpri,
    output logic                      o_rlive
);

    localparam logic [IW-1:0] MY_ID = IW'(INDEX);

    logic [OBJECT_WIDTH-1:0]   r_obj, n_obj;
    logic [PRIORITY_WIDTH-1:0] r_pri, n_pri;
    logic                      r_live, n_live;

    t_ctrl                     r_ctrl, n_ctrl;
    logic [IW-1:0]             r_id;
    logic [OBJECT_WIDTH-1:0]   r_tobj;
    logic [IW-1:0]             r_rid, n_rid;
    logic [OBJECT_WIDTH-1:0]   r_robj, n_robj;
    logic [PRIORITY_WIDTH-1:0] r_rpri, n_rpri;
    logic                      r_rlive, n_rlive;

    logic act, hit;

    assign act = i_ctrl.vld && (i_ctrl.pre == ST_OK);
    assign hit = (i_id == MY_ID);

    always_comb begin
        n_obj   = r_obj;
        n_pri   = r_pri;
        n_live  = r_live;
        n_ctrl  = i_ctrl;
        n_rid   = i_rid;
        n_robj  = i_robj;
        n_rpri  = i_rpri;
        n_rlive = i_rlive;
        if (act) begin
            case (i_ctrl.kind)
                K_ADD: begin
                    if (hit) begin
                        n_obj  = i_obj;
                        n_pri  = '0;
                        n_live = 1'b1;
                    end
                end
                K_PROMOTE: begin
                    if (hit && r_live) begin
                        n_pri        = (r_pri == '1) ? r_pri : r_pri + 1'b1;
                        n_robj       = r_obj;
                        n_rpri       = n_pri;
                        n_ctrl.found = 1'b1;
                    end
                end
                K_PEEK, K_POP: begin
                    // ascending index, so >= lets the larger id win a tie
                    if (r_live && (!i_ctrl.found || r_pri >= i_rpri)) begin
                        n_rid        = MY_ID;
                        n_robj       = r_obj;
                        n_rpri       = r_pri;
                        n_ctrl.found = 1'b1;
                    end
                end
                K_LOOKUP: begin
                    if (hit) begin
                        n_robj       = r_obj;
                        n_rpri       = r_pri;
                        n_rlive      = r_live;
                        n_ctrl.found = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_clr && (i_clr_id == MY_ID))
            n_live = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_ctrl <= '0;
        end else begin
            r_live <= n_live;
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_obj   <= n_obj;
        r_pri   <= n_pri;
        r_id    <= i_id;
        r_tobj  <= i_obj;
        r_rid   <= n_rid;
        r_robj  <= n_robj;
        r_rpri  <= n_rpri;
        r_rlive <= n_rlive;
    end

    assign o_ctrl  = r_ctrl;
    assign o_id    = r_id;
    assign o_obj   = r_tobj;
    assign o_rid   = r_rid;
    assign o_robj  = r_robj;
    assign o_rpri  = r_rpri;
    assign o_rlive = r_rlive;

endmodule

[hw/rtl/max_priority_table_with_promote.sv]
// Channel | Dir | tdata (low bit up)                                           | tuser
// s_*     | in  | entry_id[5:0] object_word[37:6]                              | kind[2:0]
// m_*     | out | out_id[5:0] out_object[37:6] out_priority[53:38] is_live[54] | status[1:0]
// One request at a time: a request walks the chain of ENTRIES cells, one cell
// per cycle, and its result is registered at the chain end; the next
// request is taken once the result has been transferred out.
// Reset (synchronous, active low) clears live flags, the id counter and the
// handshake state; object and priority stores keep their contents.
// A stalled output holds its result; the input stays not-ready meanwhile.
module max_priority_table_with_promote import mpt_pkg::*; #(
    parameter int ENTRIES        = DEF_ENTRIES,
    parameter int OBJECT_WIDTH   = DEF_OBJECT_WIDTH,
    parameter int PRIORITY_WIDTH = DEF_PRIORITY_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // entry_id, object_word
    input  logic [2:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_id, out_object, out_priority, is_live
    output logic [1:0]  m_tuser    // status
);

    localparam int IW = $clog2(ENTRIES);

    t_ctrl                     w_ctrl [ENTRIES+1];
    logic [IW-1:0]             w_id   [ENTRIES+1];
    logic [OBJECT_WIDTH-1:0]   w_obj  [ENTRIES+1];
    logic [IW-1:0]             w_rid  [ENTRIES+1];
    logic [OBJECT_WIDTH-1:0]   w_robj [ENTRIES+1];
    logic [PRIORITY_WIDTH-1:0] w_rpri [ENTRIES+1];
    logic                      w_rlive[ENTRIES+1];

    logic [IW:0]  r_next_id;
    logic         r_busy;
    logic [5:0]   r_req_id;
    logic         r_mval;
    logic [1:0]   r_status;
    logic [5:0]   r_oid;
    logic [31:0]  r_oobj;
    logic [15:0]  r_opri;
    logic         r_olive;

    logic         s_xfer, m_xfer, full, id_ok, done, clr;
    logic [1:0]   pre;
    logic [5:0]   in_id;
    logic [2:0]   in_kind;
    t_ctrl        e_ctrl;
    logic [1:0]   n_status;
    logic [5:0]   n_oid;
    logic [31:0]  n_oobj;
    logic [15:0]  n_opri;
    logic         n_olive;

    assign in_id   = s_tdata[5:0];
    assign in_kind = s_tuser;
    assign s_tready = !r_busy;
    assign s_xfer  = s_tvalid && s_tready;
    assign m_xfer  = r_mval && m_tready;
    assign full    = (r_next_id == (IW+1)'(ENTRIES));
    assign id_ok   = (32'(in_id) < 32'(r_next_id));

    always_comb begin
        case (in_kind)
            K_ADD:            pre = full ? ST_FULL : ST_OK;
            K_PROMOTE,
            K_LOOKUP:         pre = id_ok ? ST_OK : ST_BADID;
            K_PEEK, K_POP:    pre = ST_OK;
            default:          pre = ST_BADID;
        endcase
        e_ctrl.vld   = s_xfer;
        e_ctrl.kind  = in_kind;
        e_ctrl.pre   = pre;
        e_ctrl.found = 1'b0;
    end

    assign w_ctrl[0]  = e_ctrl;
    assign w_id[0]    = (in_kind == K_ADD) ? r_next_id[IW-1:0] : IW'(in_id);
    assign w_obj[0]   = OBJECT_WIDTH'(s_tdata[37:6]);
    assign w_rid[0]   = '0;
    assign w_robj[0]  = '0;
    assign w_rpri[0]  = '0;
    assign w_rlive[0] = 1'b0;

    assign done = w_ctrl[ENTRIES].vld;
    assign clr  = done && (w_ctrl[ENTRIES].kind == K_POP) &&
                  (w_ctrl[ENTRIES].pre == ST_OK) && w_ctrl[ENTRIES].found;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        mpt_cell #(
            .ENTRIES(ENTRIES), .OBJECT_WIDTH(OBJECT_WIDTH),
            .PRIORITY_WIDTH(PRIORITY_WIDTH), .INDEX(g)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_ctrl(w_ctrl[g]), .i_id(w_id[g]), .i_obj(w_obj[g]),
            .i_rid(w_rid[g]), .i_robj(w_robj[g]), .i_rpri(w_rpri[g]),
            .i_rlive(w_rlive[g]),
            .i_clr(clr), .i_clr_id(w_rid[ENTRIES]),
            .o_ctrl(w_ctrl[g+1]), .o_id(w_id[g+1]), .o_obj(w_obj[g+1]),
            .o_rid(w_rid[g+1]), .o_robj(w_robj[g+1]), .o_rpri(w_rpri[g+1]),
            .o_rlive(w_rlive[g+1])
        );
    end

    // result assembly at the chain end
    always_comb begin
        t_ctrl c;
        c        = w_ctrl[ENTRIES];
        n_status = c.pre;
        n_oid    = '0;
        n_oobj   = '0;
        n_opri   = '0;
        n_olive  = 1'b0;
        if (c.pre != ST_OK) begin
            if (c.kind == K_LOOKUP)
                n_oid = r_req_id;
        end else begin
            case (c.kind)
                K_ADD: begin
                    n_oid   = 6'(w_id[ENTRIES]);
                    n_oobj  = 32'(w_obj[ENTRIES]);
                    n_olive = 1'b1;
                end
                K_PROMOTE: begin
                    if (c.found) begin
                        n_oid   = r_req_id;
                        n_oobj  = 32'(w_robj[ENTRIES]);
                        n_opri  = 16'(w_rpri[ENTRIES]);
                        n_olive = 1'b1;
                    end else begin
                        n_status = ST_BADID;
                    end
                end
                K_PEEK, K_POP: begin
                    if (c.found) begin
                        n_oid   = 6'(w_rid[ENTRIES]);
                        n_oobj  = 32'(w_robj[ENTRIES]);
                        n_opri  = 16'(w_rpri[ENTRIES]);
                        n_olive = (c.kind == K_PEEK);
                    end else begin
                        n_status = ST_EMPTY;
                    end
                end
                K_LOOKUP: begin
                    n_oid   = r_req_id;
                    n_oobj  = 32'(w_robj[ENTRIES]);
                    n_opri  = 16'(w_rpri[ENTRIES]);
                    n_olive = w_rlive[ENTRIES];
                end
                default: n_status = ST_BADID;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_id <= '0;
            r_busy    <= 1'b0;
            r_mval    <= 1'b0;
        end else begin
            if (s_xfer && in_kind == K_ADD && !full)
                r_next_id <= r_next_id + 1'b1;
            if (s_xfer)
                r_busy <= 1'b1;
            else if (m_xfer)
                r_busy <= 1'b0;
            if (done)
                r_mval <= 1'b1;
            else if (m_xfer)
                r_mval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer)
            r_req_id <= in_id;
        if (done) begin
            r_status <= n_status;
            r_oid    <= n_oid;
            r_oobj   <= n_oobj;
            r_opri   <= n_opri;
            r_olive  <= n_olive;
        end
    end

    assign m_tvalid = r_mval;
    assign m_tuser  = r_status;
    assign m_tdata  = {1'b0, r_olive, r_opri, r_oobj, r_oid};

endmodule

[hw/rtl/mpt_checker.sv]
`include "max_priority_table_with_promote_defines.svh"

module mpt_checker import mpt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    logic err_no_payload;

    assign err_no_payload = m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_EMPTY);

    `MPT_AST_NXT(a_m_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid)
    `MPT_AST_NXT(a_one_at_a_time, i_clk, i_rst_n, s_tvalid && s_tready, !s_tready)
    `MPT_AST_NOW(a_no_take_while_out, i_clk, i_rst_n, m_tvalid, !s_tready)
    `MPT_AST_NOW(a_err_zero, i_clk, i_rst_n, err_no_payload, m_tdata == '0)

endmodule

bind max_priority_table_with_promote mpt_checker u_mpt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import mpt_pkg::*;

    localparam int NUM_ENTRIES = DEF_ENTRIES;
    localparam int LATENCY     = NUM_ENTRIES + 1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [2:0] K_BAD_LO = 3'd5;
    localparam logic [2:0] K_BAD_HI = 3'd7;

    typedef struct {
        logic [1:0]  status;
        logic [5:0]  id;
        logic [31:0] obj;
        logic [15:0] prio;
        logic        live;
    } t_table_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // entry_id, object_word
    logic [2:0]  s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;   // out_id, out_object, out_priority, is_live
    logic [1:0]  m_tuser;   // status

    // shadow copy of the table
    logic [31:0] obj_mem [NUM_ENTRIES];
    logic [15:0] prio_mem [NUM_ENTRIES];
    logic        live_mem [NUM_ENTRIES];
    int          ids_issued;

    t_table_result expected_q[$];
    int  errors = 0;
    int  cycles = 0;
    int  snd_idle;
    int  rcv_idle;
    int  hold_left = 0;
    int  hold_reqs = 0;
    int  hold_seen = 0;

    max_priority_table_with_promote dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_table_result apply_request(logic [2:0] kind, logic [5:0] id,
                                                    logic [31:0] obj);
        t_table_result r;
        int best;
        r = '{ST_OK, 6'd0, 32'd0, 16'd0, 1'b0};
        case (kind)
            K_ADD: begin
                if (ids_issued >= NUM_ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    obj_mem[ids_issued]  = obj;
                    prio_mem[ids_issued] = '0;
                    live_mem[ids_issued] = 1'b1;
                    r = '{ST_OK, 6'(ids_issued), obj, 16'd0, 1'b1};
                    ids_issued++;
                end
            end
            K_PROMOTE: begin
                if (id >= ids_issued || !live_mem[id]) begin
                    r.status = ST_BADID;
                end else begin
                    if (prio_mem[id] != 16'hFFFF) prio_mem[id] = prio_mem[id] + 1'b1;
                    r = '{ST_OK, id, obj_mem[id], prio_mem[id], 1'b1};
                end
            end
            K_PEEK, K_POP: begin
                best = -1;
                for (int i = 0; i < ids_issued; i++)
                    if (live_mem[i] && (best < 0 || prio_mem[i] >= prio_mem[best])) best = i;
                if (best < 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (kind == K_POP) live_mem[best] = 1'b0;
                    r = '{ST_OK, 6'(best), obj_mem[best], prio_mem[best], live_mem[best]};
                end
            end
            K_LOOKUP: begin
                if (id >= ids_issued) begin
                    r.status = ST_BADID;
                    r.id     = id;
                end else begin
                    r = '{ST_OK, id, obj_mem[id], prio_mem[id], live_mem[id]};
                end
            end
            default: r.status = ST_BADID;
        endcase
        return r;
    endfunction

    // offers one request; s_tvalid stays high on return so the next one can follow
    task automatic send_request(logic [2:0] kind, logic [5:0] id, logic [31:0] obj);
        int gap;
        gap = ($urandom_range(99) < snd_idle) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, obj, id};
        do @(posedge i_clk); while (!s_tready);
        expected_q.insert(expected_q.size(), apply_request(kind, id, obj));
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        logic [2:0] kind;
        logic [5:0] id;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 18)      kind = K_ADD;
            else if (pick < 55) kind = K_PROMOTE;
            else if (pick < 65) kind = K_PEEK;
            else if (pick < 77) kind = K_POP;
            else if (pick < 95) kind = K_LOOKUP;
            else                kind = 3'($urandom_range(K_BAD_LO, K_BAD_HI));
            // mostly target issued ids, and crowd promotes onto a few to build priority
            if ($urandom_range(9) == 0 || ids_issued == 0)
                id = 6'($urandom_range(63));
            else if (kind == K_PROMOTE && $urandom_range(1) == 0)
                id = 6'($urandom_range((ids_issued < 4) ? ids_issued - 1 : 3));
            else
                id = 6'($urandom_range(ids_issued - 1));
            send_request(kind, id, $urandom);
        end
    endtask

    task automatic test_empty_table();
        send_request(K_PEEK, 6'd0, 32'd0);
        send_request(K_POP, 6'd0, 32'd0);
        send_request(K_PROMOTE, 6'd0, 32'd0);
        send_request(K_LOOKUP, 6'd0, 32'd0);
        send_request(K_LOOKUP, 6'd63, 32'hFFFF_FFFF);
        for (int k = K_BAD_LO; k <= K_BAD_HI; k++)
            send_request(3'(k), 6'd63, 32'hFFFF_FFFF);
    endtask

    task automatic test_directed();
        send_request(K_ADD, 6'd0, 32'd0);
        send_request(K_ADD, 6'd63, 32'hFFFF_FFFF);
        send_request(K_ADD, 6'd0, 32'hA5A5_5A5A);
        send_request(K_PEEK, 6'd0, 32'd0);          // all at zero: largest id wins
        send_request(K_PROMOTE, 6'd0, 32'd0);
        send_request(K_PROMOTE, 6'd1, 32'd0);
        send_request(K_PEEK, 6'd0, 32'd0);          // tie at one
        send_request(K_PROMOTE, 6'd0, 32'd0);
        send_request(K_POP, 6'd0, 32'd0);
        send_request(K_PROMOTE, 6'd0, 32'd0);       // dead id
        send_request(K_LOOKUP, 6'd0, 32'd0);        // dead id keeps object
        send_request(K_LOOKUP, 6'd3, 32'd0);        // not yet issued
        send_request(K_POP, 6'd0, 32'd0);
        send_request(K_POP, 6'd0, 32'd0);
        send_request(K_POP, 6'd0, 32'd0);           // empty again
        send_request(K_PEEK, 6'd0, 32'd0);
        send_request(K_LOOKUP, 6'd2, 32'd0);
        wait_all_results();
    endtask

    task automatic test_full_table();
        while (ids_issued < NUM_ENTRIES) send_request(K_ADD, 6'($urandom), $urandom);
        send_request(K_ADD, 6'd0, 32'hFFFF_FFFF);
        send_request(K_ADD, 6'd63, 32'd1);
        send_request(K_LOOKUP, 6'd63, 32'd0);
        wait_all_results();
    endtask

    task automatic test_output_backpressure();
        hold_reqs++;
        send_random(20);
        wait_all_results();
    endtask

    task automatic test_random(int sender_idle, int receiver_idle, int count);
        snd_idle = sender_idle;
        rcv_idle = receiver_idle;
        send_random(count);
        wait_all_results();
    endtask

    // receiver side: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge i_clk) begin
        t_table_result exp_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer: tdata %h tuser %h", m_tdata, m_tuser);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (m_tuser !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
                    errors++;
                end
                if (m_tdata[5:0] !== exp_r.id) begin
                    $error("out_id: expected %0d, got %0d", exp_r.id, m_tdata[5:0]);
                    errors++;
                end
                if (m_tdata[37:6] !== exp_r.obj) begin
                    $error("out_object: expected %h, got %h", exp_r.obj, m_tdata[37:6]);
                    errors++;
                end
                if (m_tdata[53:38] !== exp_r.prio) begin
                    $error("out_priority: expected %0d, got %0d", exp_r.prio, m_tdata[53:38]);
                    errors++;
                end
                if (m_tdata[54] !== exp_r.live) begin
                    $error("is_live: expected %0d, got %0d", exp_r.live, m_tdata[54]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        ids_issued = 0;
        snd_idle   = 27;
        rcv_idle   = 70;
        for (int i = 0; i < NUM_ENTRIES; i++) live_mem[i] = 1'b0;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = K_ADD;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_directed();
        test_random(27, 70, 150);
        test_output_backpressure();
        test_full_table();
        test_random(27, 70, 200);
        test_random(70, 27, 400);
        test_random(0, 0, 400);

        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/mpt_pkg.sv
hw/rtl/mpt_cell.sv
hw/rtl/max_priority_table_with_promote.sv
hw/rtl/mpt_checker.sv
test/testbench.sv
